[design/lru_pkg.sv]
// ----------------------------------------------------------------------------
// LRU replacement package
// Shared widths, defaults and reset values for the LRU cache replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Default geometry handed to the top level.
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  // Fixed port widths.
  localparam int KEY_W  = 16;
  localparam int CFG_W  = 5;
  localparam int MISS_W = 32;

  // Value of the capacity register after reset.
  localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

[design/lru_lookup.sv]
// ----------------------------------------------------------------------------
// LRU lookup
// Parallel tag match, victim select and free-slot search over the entry table.
// ----------------------------------------------------------------------------
module lru_lookup #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  logic [((KEY_BITS < lru_pkg::KEY_W) ? KEY_BITS : lru_pkg::KEY_W)-1:0] key,
  input  logic [((KEY_BITS < lru_pkg::KEY_W) ? KEY_BITS : lru_pkg::KEY_W)-1:0]
                 entry_key [CAPACITY],
  input  logic [CAPACITY-1:0] entry_valid,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] entry_age [CAPACITY],
  input  logic [$clog2(CAPACITY+1)-1:0] live_count,
  output logic [CAPACITY-1:0] hit_vec,
  output logic [CAPACITY-1:0] victim_vec,
  output logic [CAPACITY-1:0] free_vec
);

  localparam int CNTW = $clog2(CAPACITY + 1);

  logic [CNTW-1:0]     oldest_rank;
  logic [CAPACITY-1:0] empty_vec;

  // The oldest live entry holds rank live_count-1, since live ranks are unique.
  assign oldest_rank = live_count - CNTW'(1);
  assign empty_vec   = ~entry_valid;
  // Lowest set bit of the empty mask picks the first free entry.
  assign free_vec    = empty_vec & (~empty_vec + CAPACITY'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]    = entry_valid[i] && (entry_key[i] == key);
      victim_vec[i] = entry_valid[i] && (CNTW'(entry_age[i]) == oldest_rank);
    end
  end

endmodule

[design/lru_cache_replacement.sv]
// ----------------------------------------------------------------------------
// LRU cache replacement
// Fully associative key cache with least-recently-used eviction and miss count.
// ----------------------------------------------------------------------------
// Path: a taken request sits in the input register, then one pass through the
// lookup loads the result register once that register is empty or draining.
// Throughput: one request per cycle while result_stall is low; the whole match,
// eviction and age update of the entry table happen in one pass, so requests chain.
// Reset: synchronous; all entries are invalidated at once through per-entry valid
// bits, so there is no clearing pass. Capacity returns to 16, miss count to 0.
// ----------------------------------------------------------------------------
module lru_cache_replacement #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write channel: one register, the capacity.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]   cfg_capacity,
  // Request channel.
  input  logic                        request_valid,
  output logic                        request_stall,
  input  logic [lru_pkg::KEY_W-1:0]   request_key,
  // Result channel.
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        hit,
  output logic                        evicted_valid,
  output logic [lru_pkg::KEY_W-1:0]   evicted_key,
  output logic [lru_pkg::MISS_W-1:0]  miss_count
);

  // Stored key width: keys are narrowed to KEY_BITS, at most the 16 the port carries.
  localparam int KEY_PORT_W = lru_pkg::KEY_W;
  localparam int KW   = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  // Recency rank width: ranks run from 0 to CAPACITY-1.
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Live entry count width: 0 to CAPACITY.
  localparam int CNTW = $clog2(CAPACITY + 1);
  // Width used to compare the live count against the configured capacity.
  localparam int EW   = (CNTW > lru_pkg::CFG_W) ? CNTW : lru_pkg::CFG_W;
  localparam int MW   = lru_pkg::MISS_W;

  // --------------------------------------------------------------------------
  // Capacity register. The write channel is always ready.
  // --------------------------------------------------------------------------
  logic [lru_pkg::CFG_W-1:0] capacity;
  logic [EW-1:0]             cap_ext;
  logic [EW-1:0]             eff_cap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lru_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_capacity;
    end
  end

  // A capacity of zero behaves as one, and values above the table size clamp.
  always_comb begin
    cap_ext = EW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(CAPACITY)) begin
      eff_cap = EW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Input register. It holds one request until the lookup stage can process
  // it, which happens whenever the result register is empty or draining.
  // --------------------------------------------------------------------------
  logic          req_full;
  logic [KW-1:0] req_key;
  logic          req_accept;
  logic          fire;

  assign fire          = req_full && (!result_valid || !result_stall);
  assign request_stall = req_full && !fire;
  assign req_accept    = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_accept) begin
      req_full <= 1'b1;
    end else if (fire) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_key <= request_key[KW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Entry table. Every live entry carries a unique recency rank; rank 0 is the
  // most recent one, so live ranks always form the set 0 .. live_count-1.
  // --------------------------------------------------------------------------
  logic [KW-1:0]       entry_key   [CAPACITY];
  logic [AW-1:0]       entry_age   [CAPACITY];
  logic [AW-1:0]       age_next    [CAPACITY];
  logic [CAPACITY-1:0] entry_valid;
  logic [CAPACITY-1:0] valid_next;
  logic [CAPACITY-1:0] key_write;
  logic [CNTW-1:0]     live_count;
  logic [CNTW-1:0]     live_count_next;
  logic [MW-1:0]       misses;
  logic [MW-1:0]       misses_next;

  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] victim_vec;
  logic [CAPACITY-1:0] free_vec;
  logic [CAPACITY-1:0] slot_vec;
  logic                hit_c;
  logic                evict_c;
  logic [AW-1:0]       hit_age;
  logic [KW-1:0]       ev_key;

  lru_lookup #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_lookup (
    .key         (req_key),
    .entry_key   (entry_key),
    .entry_valid (entry_valid),
    .entry_age   (entry_age),
    .live_count  (live_count),
    .hit_vec     (hit_vec),
    .victim_vec  (victim_vec),
    .free_vec    (free_vec)
  );

  // On a hit, entries more recent than the hit entry age by one and the hit
  // entry becomes most recent. On a miss, the oldest entry is replaced when the
  // table is at its configured capacity, otherwise the first free entry takes
  // the new key; all other live entries age by one.
  always_comb begin
    hit_c   = |hit_vec;
    evict_c = !hit_c && (EW'(live_count) >= eff_cap);
    slot_vec = evict_c ? victim_vec : free_vec;
    hit_age = '0;
    ev_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_age = hit_age | (hit_vec[i] ? entry_age[i] : AW'(0));
      ev_key  = ev_key | (victim_vec[i] ? entry_key[i] : KW'(0));
    end

    for (int i = 0; i < CAPACITY; i++) begin
      valid_next[i] = entry_valid[i];
      age_next[i]   = entry_age[i];
      key_write[i]  = 1'b0;
      if (hit_c) begin
        if (hit_vec[i]) begin
          age_next[i] = '0;
        end else if (entry_valid[i] && (entry_age[i] < hit_age)) begin
          age_next[i] = entry_age[i] + AW'(1);
        end
      end else begin
        if (slot_vec[i]) begin
          valid_next[i] = 1'b1;
          age_next[i]   = '0;
          key_write[i]  = 1'b1;
        end else if (entry_valid[i]) begin
          age_next[i] = entry_age[i] + AW'(1);
        end
      end
    end

    // An eviction frees one entry and the insert fills it again.
    if (hit_c || evict_c) begin
      live_count_next = live_count;
    end else begin
      live_count_next = live_count + CNTW'(1);
    end

    if (!hit_c && (misses != '1)) begin
      misses_next = misses + MW'(1);
    end else begin
      misses_next = misses;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      live_count  <= '0;
      misses      <= '0;
    end else if (fire) begin
      entry_valid <= valid_next;
      live_count  <= live_count_next;
      misses      <= misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry_age[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry_age[i] <= age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (fire && key_write[i]) begin
        entry_key[i] <= req_key;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It loads on every processed request and otherwise empties
  // once the downstream side takes the transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit           <= hit_c;
      evicted_valid <= evict_c;
      evicted_key   <= evict_c ? KEY_PORT_W'(ev_key) : '0;
      miss_count    <= misses_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The live count tracks the number of valid entries exactly.
  a_live_matches_valid : assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(live_count))
    else $error("live count does not match valid entries");

  // Keys stay unique among live entries, so at most one entry matches.
  a_single_match : assert property (@(posedge clk) disable iff (rst)
    req_full |-> $onehot0(hit_vec))
    else $error("more than one entry matches the request key");

  // An eviction always finds exactly one oldest entry.
  a_victim_found : assert property (@(posedge clk) disable iff (rst)
    (fire && evict_c) |-> $onehot(victim_vec))
    else $error("no unique victim for an eviction");

  // A hit leaves the miss count alone.
  a_hit_keeps_misses : assert property (@(posedge clk) disable iff (rst)
    (fire && hit_c) |=> (misses == $past(misses)))
    else $error("miss count changed on a hit");

  // A result never reports both a hit and an eviction.
  a_hit_no_evict : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

endmodule
